>>> rtl/clipped_colour_key_blit_core_assert.svh
// ----------------------------------------------------------------------------
// clipped_colour_key_blit_core_assert.svh
// Assertion macros for the colour key blit core.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_COLOUR_KEY_BLIT_CORE_ASSERT_SVH
`define CLIPPED_COLOUR_KEY_BLIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CKB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ckb: assertion failed");
`define CKB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ckb: assertion failed");
`else
`define CKB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CKB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/ckb_pkg.sv
// ----------------------------------------------------------------------------
// ckb_pkg
// Types and constants of the colour key blit core.
// ----------------------------------------------------------------------------
package ckb_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int SIZE_W     = 13;
	localparam int CNT_W      = 13;
	localparam int POS_W      = 16;
	localparam int PIXEL_W    = 8;
	localparam int SHIFT_W    = 9;
	localparam int ADDR_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0]  COUNT_MAX      = '1;
	localparam logic [SIZE_W-1:0] DIM_LIMIT      = SIZE_W'(MAX_DIM);
	localparam logic [SIZE_W-1:0] DEST_WIDTH_RST  = 13'd320;
	localparam logic [SIZE_W-1:0] DEST_HEIGHT_RST = 13'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_X       = 3'd0,
		REG_DEST_Y       = 3'd1,
		REG_DEST_WIDTH   = 3'd2,
		REG_DEST_HEIGHT  = 3'd3,
		REG_KEY_COLOUR   = 3'd4,
		REG_KEY_ENABLE   = 3'd5,
		REG_COLOUR_SHIFT = 3'd6
	} cfg_reg_t;

endpackage

>>> rtl/clipped_colour_key_blit_core.sv
// ----------------------------------------------------------------------------
// clipped_colour_key_blit_core
// Takes sprite pixels in row-major order (tuser marks end of row, tlast end
// of sprite) and emits one write request per pixel that lands inside the
// destination and is not keyed out: address row * dest_width + column and
// colour pixel + colour_shift. Negative placement clamps to zero. One pixel
// is taken every clock unless the output stalls; a request passes the input
// stage and the output register after the row * width multiply. The user
// must write registers only while no pixel is in flight; it is not enforced.
// ----------------------------------------------------------------------------
`include "clipped_colour_key_blit_core_assert.svh"

module clipped_colour_key_blit_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ckb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ckb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // [7:0] pixel
	input  logic                             s_axis_tuser,  // row_end
	input  logic                             s_axis_tlast,  // frame_end
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [31:0]                      m_axis_tdata   // [23:0] dest_address, [31:24] pixel_colour
);

	localparam int DIM_W  = ckb_pkg::DIM_W;
	localparam int SIZE_W = ckb_pkg::SIZE_W;
	localparam int CNT_W  = ckb_pkg::CNT_W;
	localparam int POS_W  = ckb_pkg::POS_W;
	localparam int SUM_W  = ckb_pkg::PIXEL_W + 2;
	localparam int PROD_W = DIM_W + SIZE_W;

	// configuration
	logic [POS_W-1:0]             dest_x_q;
	logic [POS_W-1:0]             dest_y_q;
	logic [SIZE_W-1:0]            dest_width_q;
	logic [SIZE_W-1:0]            dest_height_q;
	logic [ckb_pkg::PIXEL_W-1:0]  key_colour_q;
	logic                         key_enable_q;
	logic [ckb_pkg::SHIFT_W-1:0]  colour_shift_q;

	logic [CNT_W-1:0]             column_count_q;
	logic [CNT_W-1:0]             row_count_q;

	logic                         valid_s1;
	logic [DIM_W-1:0]             col_s1;
	logic [DIM_W-1:0]             row_s1;
	logic [ckb_pkg::PIXEL_W-1:0]  colour_s1;

	logic                         out_valid_q;
	logic [ckb_pkg::ADDR_W-1:0]   out_addr_q;
	logic [ckb_pkg::PIXEL_W-1:0]  out_colour_q;

	logic [POS_W-1:0]             origin_x;
	logic [POS_W-1:0]             origin_y;
	logic [POS_W:0]               col_full;
	logic [POS_W:0]               row_full;
	logic [SIZE_W-1:0]            w_lim;
	logic [SIZE_W-1:0]            h_lim;
	logic [SUM_W-1:0]             sum;
	logic                         in_dest;
	logic                         keyed;
	logic                         hit;
	logic                         out_ready;
	logic                         s1_ready;
	logic                         in_fire;
	logic [PROD_W-1:0]            prod;
	logic [PROD_W:0]              addr_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q       <= '0;
			dest_y_q       <= '0;
			dest_width_q   <= ckb_pkg::DEST_WIDTH_RST;
			dest_height_q  <= ckb_pkg::DEST_HEIGHT_RST;
			key_colour_q   <= '0;
			key_enable_q   <= 1'b0;
			colour_shift_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (ckb_pkg::cfg_reg_t'(cfg_index))
				ckb_pkg::REG_DEST_X:       dest_x_q       <= cfg_wdata[POS_W-1:0];
				ckb_pkg::REG_DEST_Y:       dest_y_q       <= cfg_wdata[POS_W-1:0];
				ckb_pkg::REG_DEST_WIDTH:   dest_width_q   <= cfg_wdata[SIZE_W-1:0];
				ckb_pkg::REG_DEST_HEIGHT:  dest_height_q  <= cfg_wdata[SIZE_W-1:0];
				ckb_pkg::REG_KEY_COLOUR:   key_colour_q   <= cfg_wdata[ckb_pkg::PIXEL_W-1:0];
				ckb_pkg::REG_KEY_ENABLE:   key_enable_q   <= cfg_wdata[0];
				ckb_pkg::REG_COLOUR_SHIFT: colour_shift_q <= cfg_wdata[ckb_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp placement and destination size
	assign origin_x = dest_x_q[POS_W-1] ? '0 : dest_x_q;
	assign origin_y = dest_y_q[POS_W-1] ? '0 : dest_y_q;
	assign w_lim    = (dest_width_q > ckb_pkg::DIM_LIMIT) ? ckb_pkg::DIM_LIMIT : dest_width_q;
	assign h_lim    = (dest_height_q > ckb_pkg::DIM_LIMIT) ? ckb_pkg::DIM_LIMIT : dest_height_q;

	assign col_full = {1'b0, origin_x} + (POS_W+1)'(column_count_q);
	assign row_full = {1'b0, origin_y} + (POS_W+1)'(row_count_q);
	assign in_dest  = (col_full < (POS_W+1)'(w_lim)) && (row_full < (POS_W+1)'(h_lim));

	// full sign-extended sum, so a negative or >255 result never matches the key
	assign sum   = SUM_W'(s_axis_tdata) + {colour_shift_q[ckb_pkg::SHIFT_W-1], colour_shift_q};
	assign keyed = key_enable_q && (sum == SUM_W'(key_colour_q));
	assign hit   = in_dest && !keyed;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign s1_ready      = !valid_s1 || out_ready;
	assign s_axis_tready = s1_ready;
	assign in_fire       = s_axis_tvalid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (in_fire) begin
			if (s_axis_tlast) begin
				column_count_q <= '0;
				row_count_q    <= '0;
			end else if (s_axis_tuser) begin
				column_count_q <= '0;
				if (row_count_q != ckb_pkg::COUNT_MAX)
					row_count_q <= row_count_q + 1'b1;
			end else if (column_count_q != ckb_pkg::COUNT_MAX) begin
				column_count_q <= column_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready)
				valid_s1 <= in_fire && hit;
			if (out_ready)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1    <= col_full[DIM_W-1:0];
			row_s1    <= row_full[DIM_W-1:0];
			colour_s1 <= sum[ckb_pkg::PIXEL_W-1:0];
		end
	end

	assign prod      = row_s1 * w_lim;
	assign addr_full = {1'b0, prod} + (PROD_W+1)'(col_s1);

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			out_addr_q   <= ckb_pkg::ADDR_W'(addr_full);
			out_colour_q <= colour_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_colour_q, out_addr_q};

	`CKB_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`CKB_ASSERT_IMP(a_s1_hit, clk, arst_n, valid_s1, ({1'b0, col_s1} < w_lim) && ({1'b0, row_s1} < h_lim))
	`CKB_ASSERT_NXT(a_row_clears, clk, arst_n, in_fire && s_axis_tlast, row_count_q == '0)
	`CKB_ASSERT_NXT(a_col_clears, clk, arst_n, in_fire && s_axis_tuser, column_count_q == '0)

endmodule
